>>> sv/fuel_injection_event_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Fuel injection event scheduler: assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FUEL_INJECTION_EVENT_SCHEDULER_ASSERT_SVH
`define FUEL_INJECTION_EVENT_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FIES_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define FIES_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define FIES_ASSERT_NEVER(label, cond, msg)
`define FIES_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

>>> sv/fies_pkg.sv
// ----------------------------------------------------------------------------
// Fuel injection event scheduler: package
// Shared constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fies_pkg;

    // defaults for the top level parameters
    localparam int TICK_WIDTH_DEF        = 32;
    localparam int MAX_ADVANCE_STEPS_DEF = 16;

    // fixed field widths
    localparam int TPS_W  = 30;
    localparam int RATE_W = 28;
    localparam int QUOT_W = 32;
    localparam int DIVC_W = $clog2(QUOT_W);

    // function codes
    localparam logic [1:0] FN_SCHED = 2'd0;
    localparam logic [1:0] FN_OPEN  = 2'd1;
    localparam logic [1:0] FN_CLOSE = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_TPS    = 2'd0;
    localparam logic [1:0] CFG_TDC    = 2'd1;
    localparam logic [1:0] CFG_ANCHOR = 2'd2;

    // anchor codes
    localparam logic [1:0] ANCH_START = 2'd0;
    localparam logic [1:0] ANCH_MID   = 2'd1;

    localparam logic [TPS_W-1:0] TPS_RESET = 30'd1000000;

    // engine cycle in degrees and in Q13.6
    localparam logic [9:0]  DEG720   = 10'd720;
    localparam logic [9:0]  DEG360   = 10'd360;
    localparam logic [18:0] CYC720_Q6 = 19'd46080;
    localparam logic [18:0] CYC360_Q6 = 19'd23040;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVT,
        S_PULSE,
        S_UNSYNC,
        S_DIV_START,
        S_DIV_WAIT,
        S_MODD,
        S_TPC,
        S_ANG,
        S_OPEN,
        S_ADV1,
        S_ADV2,
        S_FIN,
        S_DONE
    } fies_state_t;

endpackage

`default_nettype wire

>>> sv/fies_div.sv
// ----------------------------------------------------------------------------
// Fuel injection event scheduler: restoring divider
// One quotient bit per cycle from start to done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fies_div
    import fies_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RATE_W-1:0] rem_init,   // upper dividend bits, below divisor
    input  wire logic [QUOT_W-1:0] dividend_lo,
    input  wire logic [RATE_W-1:0] divisor,
    output logic                   done,
    output logic [QUOT_W-1:0]      quotient
);

    logic [RATE_W-1:0] rem_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [DIVC_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [RATE_W:0]   trial;
    logic              fits;

    // trial subtract
    assign trial = {rem_reg, q_reg[QUOT_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIVC_W'(QUOT_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            q_reg   <= dividend_lo;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? RATE_W'(trial - {1'b0, divisor}) : trial[RATE_W-1:0];
            q_reg   <= {q_reg[QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

>>> sv/fuel_injection_event_scheduler.sv
// Event items (open fired, close fired): S_EVT, S_DONE. Unsynced or disabled request:
// S_PULSE, S_UNSYNC, S_DONE. Schedule request: S_PULSE, S_DIV_START, S_DIV_WAIT,
// S_MODD (once per angle-reduction step, up to 9), S_TPC, S_ANG, S_OPEN, S_ADV1 and
// S_ADV2 (up to 2*MAX_ADVANCE_STEPS tick-advance steps), S_FIN, S_DONE; S_DIV_WAIT is
// skipped when ticks per degree saturates. Output stalls hold S_DONE; one item at a time.
// Reset (rst_n low, asynchronous) clears all injector state, registers to defaults.
// ----------------------------------------------------------------------------
// Fuel injection event scheduler: top level
// Turns crank-angle schedule requests into injector open and close ticks
// using one shared multiplier and a divider under a small sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fuel_injection_event_scheduler_assert.svh"

module fuel_injection_event_scheduler
    import fies_pkg::*;
#(
    parameter int TICK_WIDTH        = TICK_WIDTH_DEF,
    parameter int MAX_ADVANCE_STEPS = MAX_ADVANCE_STEPS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // current_tick, synced, sequential, crank_position, position_rate,
    // calc_tick, enable, pulse_width, inject_angle, fired_tick
    input  wire logic [183:0] s_tdata,
    input  wire logic [1:0]   s_tuser,    // func
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // open_tick, close_tick, injector_open, open_pending, close_pending, pad
    output logic [71:0]       m_tdata,
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [29:0]  cfg_data
);

    localparam int TW    = TICK_WIDTH;
    localparam int CNT_W = $clog2(MAX_ADVANCE_STEPS + 1);

    fies_state_t state_reg, state_next;

    // configuration
    logic [TPS_W-1:0] tps_reg;
    logic [16:0]      tdc_reg;
    logic [1:0]       anchor_reg;

    // captured item
    logic [1:0]        func_reg;
    logic [TW-1:0]     now_reg, calc_reg, fired_reg;
    logic              run_reg, seq_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [23:0]       pw_reg;
    logic signed [18:0] d_reg;

    // injector state
    logic          is_open_reg, open_sched_reg, close_sched_reg;
    logic [TW-1:0] last_open_reg, open_target_reg, close_target_reg;

    // working values
    logic [TW-1:0]     pulse_reg, tpc_reg, ang_reg, open_at_reg, half_reg;
    logic [QUOT_W-1:0] tpd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TW-1:0]     res_open_reg, res_close_reg;
    logic              m_valid_reg;
    logic [71:0]       m_data_reg;

    // control
    logic        div_start, div_done, tpd_sat, out_free;
    logic [QUOT_W-1:0] div_q;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    // shared multiplier
    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    // divider for ticks per degree
    assign tpd_sat = {6'd0, tps_reg[TPS_W-1:8]} >= rate_reg;

    fies_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .rem_init    ({6'd0, tps_reg[TPS_W-1:8]}),
        .dividend_lo ({tps_reg[7:0], 24'd0}),
        .divisor     (rate_reg),
        .done        (div_done),
        .quotient    (div_q)
    );

    // open tick and reseed test
    logic [TW-1:0]  anc_term, open_at_w, span_w;
    logic [TW+1:0]  tpc3;
    logic [TW-1:0]  diff_a, diff_b, diff_c, diff_d, probe, c_unsync;
    logic           reseed, adv1, adv2, d_neg, d_big;
    logic [18:0]    cyc_q6;

    always_comb
    begin
        case (anchor_reg)
            ANCH_START: anc_term = '0;
            ANCH_MID:   anc_term = pulse_reg >> 1;
            default:    anc_term = pulse_reg;
        endcase
    end

    assign open_at_w = ang_reg + calc_reg - (tpc_reg << 1) - anc_term;
    assign tpc3      = {2'b00, tpc_reg} + {1'b0, tpc_reg, 1'b0};
    assign span_w    = tpc3[TW:1];
    assign diff_a    = (last_open_reg + pulse_reg) - (calc_reg - span_w);
    assign diff_b    = (calc_reg + span_w) - last_open_reg;
    assign reseed    = !open_sched_reg && (last_open_reg == '0 || diff_a[TW-1] || diff_b[TW-1]);

    // advance loops
    assign diff_c = last_open_reg - (now_reg - tpc_reg);
    assign adv1   = (cnt_reg < CNT_W'(MAX_ADVANCE_STEPS)) && diff_c[TW-1];
    assign probe  = is_open_reg ? (open_at_reg + half_reg) : (open_at_reg - half_reg);
    assign diff_d = probe - last_open_reg;
    assign adv2   = (cnt_reg < CNT_W'(MAX_ADVANCE_STEPS)) && diff_d[TW-1];

    // angle reduction
    assign cyc_q6 = seq_reg ? CYC720_Q6 : CYC360_Q6;
    assign d_neg  = d_reg[18];
    assign d_big  = !d_neg && (d_reg >= $signed(cyc_q6));

    assign c_unsync = last_open_reg + pulse_reg;
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = (s_tuser != FN_SCHED) ? S_EVT : S_PULSE;
            S_EVT:       state_next = S_DONE;
            S_PULSE:     state_next = run_reg ? S_DIV_START : S_UNSYNC;
            S_UNSYNC:    state_next = S_DONE;
            S_DIV_START: state_next = tpd_sat ? S_MODD : S_DIV_WAIT;
            S_DIV_WAIT:  if (div_done) state_next = S_MODD;
            S_MODD:      if (!d_neg && !d_big) state_next = S_TPC;
            S_TPC:       state_next = S_ANG;
            S_ANG:       state_next = S_OPEN;
            S_OPEN:      state_next = reseed ? S_ADV1 : S_ADV2;
            S_ADV1:      if (!adv1) state_next = S_ADV2;
            S_ADV2:      if (!adv2) state_next = S_FIN;
            S_FIN:       state_next = S_DONE;
            S_DONE:      if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = (state_reg == S_IDLE);
        div_start = (state_reg == S_DIV_START) && !tpd_sat;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            S_PULSE:
            begin
                mul_a = {8'd0, pw_reg};
                mul_b = {2'd0, tps_reg};
            end
            S_TPC:
            begin
                mul_a = tpd_reg;
                mul_b = {22'd0, seq_reg ? DEG720 : DEG360};
            end
            S_ANG:
            begin
                mul_a = tpd_reg;
                mul_b = {16'd0, d_reg[15:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tps_reg          <= TPS_RESET;
            tdc_reg          <= '0;
            anchor_reg       <= ANCH_START;
            is_open_reg      <= 1'b0;
            open_sched_reg   <= 1'b0;
            close_sched_reg  <= 1'b0;
            last_open_reg    <= '0;
            open_target_reg  <= '0;
            close_target_reg <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TPS:    tps_reg    <= cfg_data;
                    CFG_TDC:    tdc_reg    <= cfg_data[16:0];
                    CFG_ANCHOR: anchor_reg <= cfg_data[1:0];
                    default:    ;
                endcase
            end

            // result beat valid: raised on leaving S_DONE, dropped once taken
            if (state_reg == S_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;

            case (state_reg)
                S_EVT:
                begin
                    if (func_reg == FN_OPEN)
                    begin
                        if (!is_open_reg)
                            last_open_reg <= (fired_reg == '0) ? TW'(1) : fired_reg;
                        is_open_reg    <= 1'b1;
                        open_sched_reg <= 1'b0;
                    end
                    else if (func_reg == FN_CLOSE)
                    begin
                        is_open_reg     <= 1'b0;
                        close_sched_reg <= 1'b0;
                    end
                end
                S_UNSYNC:
                begin
                    open_sched_reg <= 1'b0;
                    if (!close_sched_reg && is_open_reg)
                    begin
                        close_sched_reg  <= 1'b1;
                        close_target_reg <= c_unsync;
                        last_open_reg    <= '0;
                    end
                end
                S_OPEN:
                    if (reseed)
                        last_open_reg <= open_at_w;
                S_ADV1:
                    if (adv1)
                        last_open_reg <= last_open_reg + tpc_reg;
                S_FIN:
                begin
                    open_sched_reg   <= 1'b1;
                    close_sched_reg  <= 1'b1;
                    open_target_reg  <= is_open_reg ? (open_at_reg + tpc_reg) : open_at_reg;
                    close_target_reg <= is_open_reg ? (last_open_reg + pulse_reg)
                                                    : (open_at_reg + pulse_reg);
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_reg  <= s_tuser;
                    now_reg   <= TW'(s_tdata[31:0]);
                    run_reg   <= s_tdata[32] && s_tdata[110];
                    seq_reg   <= s_tdata[33];
                    rate_reg  <= (s_tdata[77:50] == '0) ? RATE_W'(1) : s_tdata[77:50];
                    calc_reg  <= TW'(s_tdata[109:78]);
                    pw_reg    <= s_tdata[134:111];
                    fired_reg <= TW'(s_tdata[183:152]);
                    d_reg     <= {{2{tdc_reg[16]}}, tdc_reg}
                               - {{2{s_tdata[151]}}, s_tdata[151:135]}
                               - {3'd0, s_tdata[49:34]};
                end
            end
            S_PULSE:     pulse_reg <= TW'(prod >> 24);
            S_DIV_START: if (tpd_sat) tpd_reg <= '1;
            S_DIV_WAIT:  if (div_done) tpd_reg <= div_q;
            S_MODD:
            begin
                if (d_neg)
                    d_reg <= d_reg + $signed(cyc_q6);
                else if (d_big)
                    d_reg <= d_reg - $signed(cyc_q6);
            end
            S_TPC:       tpc_reg <= TW'(prod >> 16);
            S_ANG:       ang_reg <= TW'(prod >> 22);
            S_OPEN:
            begin
                open_at_reg <= open_at_w;
                half_reg    <= tpc_reg >> 1;
                cnt_reg     <= '0;
            end
            S_ADV1:
            begin
                if (adv1)
                    cnt_reg <= cnt_reg + 1'b1;
                else
                    cnt_reg <= '0;
            end
            S_ADV2:
            begin
                if (adv2)
                begin
                    open_at_reg <= open_at_reg + tpc_reg;
                    cnt_reg     <= cnt_reg + 1'b1;
                end
            end
            S_EVT:
            begin
                res_open_reg  <= ((func_reg != FN_OPEN) && open_sched_reg) ? open_target_reg : '0;
                res_close_reg <= ((func_reg != FN_CLOSE) && close_sched_reg)
                                 ? close_target_reg : '0;
            end
            S_UNSYNC:
            begin
                res_open_reg  <= '0;
                res_close_reg <= (!close_sched_reg && is_open_reg) ? c_unsync : '0;
            end
            S_FIN:
            begin
                res_open_reg  <= is_open_reg ? (open_at_reg + tpc_reg) : open_at_reg;
                res_close_reg <= is_open_reg ? (last_open_reg + pulse_reg)
                                             : (open_at_reg + pulse_reg);
            end
            S_DONE:
                if (out_free)
                    m_data_reg <= {5'd0, close_sched_reg, open_sched_reg, is_open_reg,
                                   32'(res_close_reg), 32'(res_open_reg)};
            default: ;
        endcase
    end

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    // checks
    `FIES_ASSERT_NEVER(a_cnt_bound, (state_reg == S_ADV1 || state_reg == S_ADV2) &&
                       cnt_reg > CNT_W'(MAX_ADVANCE_STEPS), "advance count overrun")
    `FIES_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    `FIES_ASSERT_NEXT(a_fin_pending, state_reg == S_FIN, open_sched_reg && close_sched_reg,
                      "schedule left events unset")

endmodule

`default_nettype wire
